[rtl/core/pnc_pkg.sv]
// shared types and constants for the path name condenser
// no dependencies; imported by every module of the block
package pnc_pkg;

  localparam logic [7:0] SEP_CHAR = 8'h2F;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  localparam int CMD_SLOTS = 3;

  // one queued command: up to three output items made by one input byte
  typedef struct packed {
    logic [CMD_SLOTS-1:0][7:0] chars;  // chars[0] goes out first
    logic [1:0]                cnt;    // number of items, 1 to 3
    logic                      valid;  // 0 for a bare end marker
    logic                      last;   // last item closes the path
  } cmd_t;

endpackage

[rtl/core/pnc_front.sv]
// front end: scans path bytes and turns each byte that makes output into a queued command
// depends on pnc_pkg
module pnc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          net_root_enable,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          push,
  output pnc_pkg::cmd_t cmd
);
  import pnc_pkg::*;

  typedef enum logic [4:0] {
    PH_START     = 5'b00001,
    PH_LEAD_DOT  = 5'b00010,
    PH_NORMAL    = 5'b00100,
    PH_SLASH     = 5'b01000,
    PH_SLASH_DOT = 5'b10000
  } phase_t;

  phase_t     phase, phase_next;
  logic       began_slash, began_slash_next;
  logic       emitted_any;
  logic [1:0] n;
  logic [CMD_SLOTS-1:0][7:0] chars;
  logic       is_sep, is_dot, bare;

  assign is_sep = (in_byte == SEP_CHAR);
  assign is_dot = (in_byte == DOT_CHAR);

  always_comb begin
    n                = 2'd0;
    chars            = '0;
    phase_next       = phase;
    began_slash_next = began_slash;
    bare             = 1'b0;
    unique case (phase)
      PH_START: begin
        began_slash_next = is_sep;
        if (is_dot) begin
          phase_next = PH_LEAD_DOT;
        end else if (is_sep && !net_root_enable) begin
          phase_next = PH_SLASH;
        end else begin
          chars[0]   = in_byte;
          n          = 2'd1;
          phase_next = PH_NORMAL;
        end
      end
      PH_LEAD_DOT: begin
        phase_next = PH_NORMAL;
        if (!is_sep) begin
          chars[0] = DOT_CHAR;
          chars[1] = in_byte;
          n        = 2'd2;
        end
      end
      PH_SLASH: begin
        if (is_sep) begin
          phase_next = PH_SLASH;
        end else if (is_dot) begin
          phase_next = PH_SLASH_DOT;
        end else begin
          chars[0]   = SEP_CHAR;
          chars[1]   = in_byte;
          n          = 2'd2;
          phase_next = PH_NORMAL;
        end
      end
      PH_SLASH_DOT: begin
        if (is_sep) begin
          phase_next = PH_SLASH;
        end else begin
          chars[0]   = SEP_CHAR;
          chars[1]   = DOT_CHAR;
          chars[2]   = in_byte;
          n          = 2'd3;
          phase_next = PH_NORMAL;
        end
      end
      PH_NORMAL: begin
        if (is_sep) begin
          phase_next = PH_SLASH;
        end else begin
          chars[0] = in_byte;
          n        = 2'd1;
        end
      end
      default: begin
        phase_next = PH_START;
      end
    endcase

    // end of path fix-ups; each only applies when this byte made no items
    if (in_last) begin
      if (phase_next == PH_LEAD_DOT) begin
        chars[0] = DOT_CHAR;
        n        = 2'd1;
      end
      if (!emitted_any && n == 2'd0) begin
        chars[0] = began_slash_next ? SEP_CHAR : DOT_CHAR;
        n        = 2'd1;
      end
      if (n == 2'd0) begin
        chars[0] = NUL_CHAR;
        n        = 2'd1;
        bare     = 1'b1;
      end
    end
  end

  assign push      = in_fire && (n != 2'd0);
  assign cmd.chars = chars;
  assign cmd.cnt   = n;
  assign cmd.valid = !bare;
  assign cmd.last  = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      began_slash <= 1'b0;
      emitted_any <= 1'b0;
    end else if (in_fire) begin
      if (in_last) begin
        phase       <= PH_START;
        began_slash <= 1'b0;
        emitted_any <= 1'b0;
      end else begin
        phase       <= phase_next;
        began_slash <= began_slash_next;
        emitted_any <= emitted_any | (n != 2'd0);
      end
    end
  end

endmodule

[rtl/core/pnc_queue.sv]
// small command queue between the scanner and the serialiser
// depends on pnc_pkg
module pnc_queue #(
  parameter int AW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pnc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output pnc_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import pnc_pkg::*;

  localparam int DEPTH = 2 ** AW;

  cmd_t          slots [DEPTH];
  logic [AW:0]   wptr, rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign head  = slots[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr[AW-1:0]] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

endmodule

[rtl/core/pnc_back.sv]
// back end: walks the head command one item per cycle, while the output is not stalled, into the output register
// depends on pnc_pkg
module pnc_back (
  input  logic          clk,
  input  logic          rst,
  input  pnc_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tuser,
  output logic          out_tlast
);
  import pnc_pkg::*;

  logic [1:0] idx;
  logic       load, take, at_end;

  assign load   = !out_tvalid || out_tready;
  assign take   = load && !empty;
  assign at_end = (idx == head.cnt - 2'd1);
  assign pop    = take && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (load) begin
        out_tvalid <= !empty;
      end
      if (take) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_tdata <= head.chars[idx];
      out_tuser <= head.valid;
      out_tlast <= head.last && at_end;
    end
  end

endmodule

[rtl/core/path_name_condenser.sv]
// path name condenser top level: register port, scanner, queue and serialiser
// depends on pnc_pkg, pnc_front, pnc_queue, pnc_back
//
// Takes one path byte per request and, while the queue is not full, one
// byte per cycle. Each byte turns into zero to three output items; those go
// into a queue of 2**QDEPTH_LOG2 commands and leave one item per cycle,
// while the consumer is ready, from the output register; input stalls only
// when the queue fills, behind a slow or stalled consumer or bytes that make
// several items. An accepted byte's first item passes through a queue slot
// and then the output register. tuser low marks a bare end marker (data zero,
// tlast high). net_root_enable is taken from the register port at address 0
// and is only sampled on the first byte of a path.
module path_name_condenser #(
  parameter int QDEPTH_LOG2 = 2
) (
  input  logic        clk,
  input  logic        rst,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] out_valid
  output logic        m_axis_tlast
);
  import pnc_pkg::*;

  localparam logic REG_NET_ROOT = 1'b0;

  logic net_root_enable;
  logic in_fire, q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, head;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NET_ROOT) ? {31'd0, net_root_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      net_root_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NET_ROOT) begin
      net_root_enable <= pwdata[0];
    end
  end

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  pnc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .net_root_enable (net_root_enable),
    .in_fire         (in_fire),
    .in_byte         (s_axis_tdata),
    .in_last         (s_axis_tlast),
    .push            (q_push),
    .cmd             (push_cmd)
  );

  pnc_queue #(
    .AW (QDEPTH_LOG2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pnc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser),
    .out_tlast  (m_axis_tlast)
  );

  // the closing byte of a path always queues a command
  a_last_queues: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_axis_tlast |-> q_push)
    else $error("closing byte made no command");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue underflow");

  // a bare end marker carries zero and closes the path
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == NUL_CHAR)
    else $error("bare end marker malformed");

endmodule
